### sv/abp_pkg.sv
// Package for the alarm buzzer pattern controller.
// Holds the shared types, register index and event codes, reset values and the
// wrap-around deadline helper. No dependencies.
`timescale 1ns / 1ps

package abp_pkg;

    // Widths fixed by the poll and register formats
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned INDEX_W = 3;

    // Register reset values (milliseconds)
    localparam logic [CFG_W-1:0] SOS_TIMEOUT_RST    = 16'd3000;
    localparam logic [CFG_W-1:0] SOS_TOGGLE_RST     = 16'd250;
    localparam logic [CFG_W-1:0] GAS_BEEP_ON_RST    = 16'd70;
    localparam logic [CFG_W-1:0] GAS_BEEP_PERIOD_RST = 16'd900;
    localparam logic [CFG_W-1:0] CLICK_RST          = 16'd50;

    // Configuration register indexes
    typedef enum logic [INDEX_W-1:0] {
        REG_SOS_TIMEOUT     = 3'd0,
        REG_SOS_TOGGLE      = 3'd1,
        REG_GAS_BEEP_ON     = 3'd2,
        REG_GAS_BEEP_PERIOD = 3'd3,
        REG_CLICK           = 3'd4
    } t_reg_index;

    // Alarm event codes reported with each result
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_RAISED  = 2'd1,
        EV_CLEARED = 2'd2
    } t_event;

    typedef struct packed {
        logic [CFG_W-1:0] alarm_hold_ms;
        logic [CFG_W-1:0] sos_toggle_ms;
        logic [CFG_W-1:0] beep_len_ms;
        logic [CFG_W-1:0] gas_beep_period_ms;
        logic [CFG_W-1:0] click_ms;
    } t_cfg;

    // One poll word
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              sos_pressed;
        logic              gas_held;
        logic              emergency_stop;
        logic              speed_change_pending;
    } t_poll;

    // One result word
    typedef struct packed {
        logic   buzzer_on;
        logic   alarm_active;
        t_event alarm_event;
        logic   speed_change_taken;
    } t_result;

    // Controller state carried from poll to poll
    typedef struct packed {
        logic              alarm_latched;
        logic [TIME_W-1:0] alarm_start_time;
        logic              toggle_phase;
        logic [TIME_W-1:0] last_toggle_time;
        logic              gas_beep_on;
        logic              gas_held_before;
        logic [TIME_W-1:0] gas_beep_end_time;
        logic [TIME_W-1:0] next_gas_beep_time;
        logic              next_gas_valid;
        logic [TIME_W-1:0] click_end_time;
        logic              click_valid;
        logic              buzzer_level;
    } t_state;

    // Deadline reached when (now - deadline) read as signed is not negative
    function automatic logic reached(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] deadline);
        logic [TIME_W-1:0] diff;
        diff = now - deadline;
        return ~diff[TIME_W-1];
    endfunction

endpackage

### sv/alarm_buzzer_pattern_controller.sv
// A poll word is captured in the input register, worked by abp_step, and its result word is
// held in the result register that drives the outputs. Throughput: one poll word per cycle
// unless results stall; the state update sits in one register stage, so each poll sees the
// state left by the one before it in the same cycle it is worked.
// Reset (synchronous, active low): alarm off, buzzer silent, no deadlines running,
// registers back to 3000/250/70/900/50 ms, both pipeline stages empty.
// Depends on abp_pkg and abp_step.
`timescale 1ns / 1ps

module alarm_buzzer_pattern_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // poll channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [abp_pkg::TIME_W-1:0]    i_now_ms,
    input  logic                          i_sos_pressed,
    input  logic                          i_gas_held,
    input  logic                          i_emergency_stop,
    input  logic                          i_speed_change_pending,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_buzzer_on,
    output logic                          o_alarm_active,
    output logic [1:0]                    o_alarm_event,
    output logic                          o_speed_change_taken,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [abp_pkg::INDEX_W-1:0]   i_cfg_index,
    input  logic [abp_pkg::CFG_W-1:0]     i_cfg_data
);

    abp_pkg::t_cfg    r_cfg;
    abp_pkg::t_poll   r_poll;
    logic             r_in_valid;
    abp_pkg::t_state  r_state;
    abp_pkg::t_state  n_state;
    abp_pkg::t_result r_result;
    abp_pkg::t_result n_result;
    logic             r_out_valid;
    logic             advance;

    // A poll is worked when the result register is free or being emptied
    assign advance    = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alarm_hold_ms      <= abp_pkg::SOS_TIMEOUT_RST;
            r_cfg.sos_toggle_ms      <= abp_pkg::SOS_TOGGLE_RST;
            r_cfg.beep_len_ms        <= abp_pkg::GAS_BEEP_ON_RST;
            r_cfg.gas_beep_period_ms <= abp_pkg::GAS_BEEP_PERIOD_RST;
            r_cfg.click_ms           <= abp_pkg::CLICK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                abp_pkg::REG_SOS_TIMEOUT:     r_cfg.alarm_hold_ms      <= i_cfg_data;
                abp_pkg::REG_SOS_TOGGLE:      r_cfg.sos_toggle_ms      <= i_cfg_data;
                abp_pkg::REG_GAS_BEEP_ON:     r_cfg.beep_len_ms        <= i_cfg_data;
                abp_pkg::REG_GAS_BEEP_PERIOD: r_cfg.gas_beep_period_ms <= i_cfg_data;
                abp_pkg::REG_CLICK:           r_cfg.click_ms           <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_poll.now_ms               <= i_now_ms;
            r_poll.sos_pressed          <= i_sos_pressed;
            r_poll.gas_held             <= i_gas_held;
            r_poll.emergency_stop       <= i_emergency_stop;
            r_poll.speed_change_pending <= i_speed_change_pending;
        end
    end

    // Per-poll update logic
    abp_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_poll   (r_poll),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_buzzer_on          = r_result.buzzer_on;
    assign o_alarm_active       = r_result.alarm_active;
    assign o_alarm_event        = r_result.alarm_event;
    assign o_speed_change_taken = r_result.speed_change_taken;

endmodule

### sv/abp_step.sv
// Next-state and result logic for one poll of the buzzer controller.
// Purely combinational; depends on abp_pkg.
`timescale 1ns / 1ps

module abp_step (
    input  abp_pkg::t_state  i_state,
    input  abp_pkg::t_cfg    i_cfg,
    input  abp_pkg::t_poll   i_poll,
    output abp_pkg::t_state  o_state,
    output abp_pkg::t_result o_result
);

    always_comb begin
        abp_pkg::t_state          s;
        abp_pkg::t_event          ev;
        logic                     taken;
        logic                     gas;
        logic [abp_pkg::TIME_W-1:0] now;

        s     = i_state;
        ev    = abp_pkg::EV_NONE;
        taken = 1'b0;
        now   = i_poll.now_ms;
        gas   = i_poll.gas_held & ~i_poll.emergency_stop;

        // SOS press: restart hold-off, raise alarm if not yet latched
        if (i_poll.sos_pressed) begin
            s.alarm_start_time = now;
            if (!s.alarm_latched) begin
                s.alarm_latched = 1'b1;
                s.gas_beep_on   = 1'b0;
                ev              = abp_pkg::EV_RAISED;
            end
        end

        if (s.alarm_latched) begin
            // Alarm: toggle each interval until the hold-off runs out
            if ((now - s.alarm_start_time) < {16'd0, i_cfg.alarm_hold_ms}) begin
                if ((now - s.last_toggle_time) >= {16'd0, i_cfg.sos_toggle_ms}) begin
                    s.toggle_phase     = ~s.toggle_phase;
                    s.buzzer_level     = s.toggle_phase;
                    s.last_toggle_time = now;
                end
            end else begin
                s.alarm_latched = 1'b0;
                s.buzzer_level  = 1'b0;
                ev              = abp_pkg::EV_CLEARED;
            end
        end else begin
            // Throttle beeps
            if (gas && !s.gas_held_before) begin
                s.next_gas_beep_time = now;
                s.next_gas_valid     = 1'b1;
            end
            if (!gas) begin
                s.gas_beep_on        = 1'b0;
                s.next_gas_valid     = 1'b0;
                s.next_gas_beep_time = '0;
                s.buzzer_level       = 1'b0;
            end else if (!s.gas_beep_on && (!s.next_gas_valid ||
                         abp_pkg::reached(now, s.next_gas_beep_time))) begin
                s.gas_beep_on        = 1'b1;
                s.gas_beep_end_time  = now + {16'd0, i_cfg.beep_len_ms};
                s.next_gas_beep_time = now + {16'd0, i_cfg.gas_beep_period_ms};
                s.next_gas_valid     = 1'b1;
                s.buzzer_level       = 1'b1;
            end else if (s.gas_beep_on && abp_pkg::reached(now, s.gas_beep_end_time)) begin
                s.gas_beep_on  = 1'b0;
                s.buzzer_level = 1'b0;
            end
            s.gas_held_before = gas;
        end

        // Speed-change click: start, then end once its deadline is reached
        if (!s.alarm_latched && !s.gas_beep_on && i_poll.speed_change_pending) begin
            taken            = 1'b1;
            s.click_end_time = now + {16'd0, i_cfg.click_ms};
            s.click_valid    = 1'b1;
            s.buzzer_level   = 1'b1;
        end
        if (!s.alarm_latched && !s.gas_beep_on && s.click_valid &&
            abp_pkg::reached(now, s.click_end_time)) begin
            s.click_valid    = 1'b0;
            s.click_end_time = '0;
            s.buzzer_level   = 1'b0;
        end

        o_state                     = s;
        o_result.buzzer_on          = s.buzzer_level;
        o_result.alarm_active       = s.alarm_latched;
        o_result.alarm_event        = ev;
        o_result.speed_change_taken = taken;
    end

endmodule

### sv/abp_chk.sv
// Port-level checks for the alarm buzzer pattern controller, bound to the top level.
// Depends on abp_pkg for the event codes.
`timescale 1ns / 1ps

module abp_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_buzzer_on,
    input logic       o_alarm_active,
    input logic [1:0] o_alarm_event,
    input logic       o_speed_change_taken
);

    // A raised alarm is latched in the same word
    a_raised_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alarm_event == abp_pkg::EV_RAISED) |-> o_alarm_active)
        else $error("alarm raised but not reported active");

    // A cleared alarm is no longer latched
    a_cleared_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alarm_event == abp_pkg::EV_CLEARED) |-> !o_alarm_active)
        else $error("alarm cleared but still active");

    // A speed change is never taken over a latched alarm
    a_click_no_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_speed_change_taken) |-> !o_alarm_active)
        else $error("speed change taken during alarm");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_buzzer_on) && $stable(o_alarm_active) &&
             $stable(o_alarm_event) && $stable(o_speed_change_taken)))
        else $error("result word changed while stalled");

endmodule

bind alarm_buzzer_pattern_controller abp_chk u_abp_chk (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_buzzer_on          (o_buzzer_on),
    .o_alarm_active       (o_alarm_active),
    .o_alarm_event        (o_alarm_event),
    .o_speed_change_taken (o_speed_change_taken)
);

### tb/sv/tb_alarm_buzzer_pattern_controller.sv
// Self-checking testbench for alarm_buzzer_pattern_controller.
// Polls go in through a queue-fed driver, results are checked against an in-bench
// predictor of the SOS, throttle-beep and click logic. Depends on abp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_alarm_buzzer_pattern_controller;

    // Clock, reset and DUT connections
    logic                           i_clk = 1'b0;
    logic                           rst_n = 1'b0;
    abp_pkg::t_poll                 poll_word = '0;
    logic                           poll_valid = 1'b0;
    logic                           o_in_ready;
    logic                           res_ready = 1'b0;
    logic                           o_out_valid;
    logic                           o_buzzer_on;
    logic                           o_alarm_active;
    logic [1:0]                     o_alarm_event;
    logic                           o_speed_change_taken;
    logic                           cfg_we = 1'b0;
    abp_pkg::t_reg_index            cfg_index = abp_pkg::REG_SOS_TIMEOUT;
    logic [abp_pkg::CFG_W-1:0]      cfg_data = '0;

    // Stimulus and scoreboard
    abp_pkg::t_poll   poll_q[$];
    abp_pkg::t_result buzzer_expect_q[$];
    int         n_queued = 0;
    int         n_accepted = 0;
    int         mismatches = 0;
    int         n_raised = 0;
    int         n_cleared = 0;
    int         n_clicks = 0;
    int         n_settings = 0;
    logic       poll_accepted = 1'b0;
    int         send_gap = 0;
    int         stall_left = 0;
    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    abp_pkg::t_result exp_res;
    abp_pkg::t_result pred_res;

    // Random stimulus levels carried from poll to poll
    logic [abp_pkg::TIME_W-1:0] sim_ms = '0;
    logic       lvl_sos = 1'b0;
    logic       lvl_gas = 1'b0;
    logic       lvl_estop = 1'b0;
    logic       lvl_pend = 1'b0;

    // Predictor copy of registers and state
    abp_pkg::t_cfg regs = '{abp_pkg::SOS_TIMEOUT_RST, abp_pkg::SOS_TOGGLE_RST,
                            abp_pkg::GAS_BEEP_ON_RST, abp_pkg::GAS_BEEP_PERIOD_RST,
                            abp_pkg::CLICK_RST};
    logic                       sos_latched = 1'b0;
    logic [abp_pkg::TIME_W-1:0] sos_mark_ms = '0;
    logic                       blink_phase = 1'b0;
    logic [abp_pkg::TIME_W-1:0] blink_mark_ms = '0;
    logic                       beep_sounding = 1'b0;
    logic                       throttle_prev = 1'b0;
    logic [abp_pkg::TIME_W-1:0] beep_stop_ms = '0;
    logic [abp_pkg::TIME_W-1:0] beep_next_ms = '0;
    logic                       beep_next_armed = 1'b0;
    logic [abp_pkg::TIME_W-1:0] click_stop_ms = '0;
    logic                       click_armed = 1'b0;
    logic                       buzz_level = 1'b0;

    alarm_buzzer_pattern_controller dut (
        .i_clk                  (i_clk),
        .i_rst_n                (rst_n),
        .i_in_valid             (poll_valid),
        .o_in_ready             (o_in_ready),
        .i_now_ms               (poll_word.now_ms),
        .i_sos_pressed          (poll_word.sos_pressed),
        .i_gas_held             (poll_word.gas_held),
        .i_emergency_stop       (poll_word.emergency_stop),
        .i_speed_change_pending (poll_word.speed_change_pending),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (res_ready),
        .o_buzzer_on            (o_buzzer_on),
        .o_alarm_active         (o_alarm_active),
        .o_alarm_event          (o_alarm_event),
        .o_speed_change_taken   (o_speed_change_taken),
        .i_cfg_we               (cfg_we),
        .i_cfg_index            (cfg_index),
        .i_cfg_data             (cfg_data)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Throttle and click deadlines: reached once the wrapped difference is not negative
    function automatic logic deadline_met(input logic [abp_pkg::TIME_W-1:0] now_v,
                                          input logic [abp_pkg::TIME_W-1:0] mark);
        return $signed(now_v - mark) >= 0;
    endfunction

    // Works out the result word of one poll and advances the predicted state
    task automatic buzzer_predict(input abp_pkg::t_poll p, output abp_pkg::t_result r);
        logic [abp_pkg::TIME_W-1:0] t;
        logic [abp_pkg::TIME_W-1:0] held_for;
        logic [abp_pkg::TIME_W-1:0] since_blink;
        logic                       throttle;
        abp_pkg::t_event            ev;
        logic                       took;
        t = p.now_ms;
        ev = abp_pkg::EV_NONE;
        took = 1'b0;
        // SOS press latches the alarm and restarts its hold-off
        if (p.sos_pressed) begin
            sos_mark_ms = t;
            if (!sos_latched) begin
                sos_latched = 1'b1;
                beep_sounding = 1'b0;
                ev = abp_pkg::EV_RAISED;
            end
        end
        if (sos_latched) begin
            held_for = t - sos_mark_ms;
            since_blink = t - blink_mark_ms;
            if (held_for < 32'(regs.alarm_hold_ms)) begin
                if (since_blink >= 32'(regs.sos_toggle_ms)) begin
                    blink_phase = !blink_phase;
                    buzz_level = blink_phase;
                    blink_mark_ms = t;
                end
            end else begin
                sos_latched = 1'b0;
                buzz_level = 1'b0;
                ev = abp_pkg::EV_CLEARED;
            end
        end else begin
            // throttle beeps, masked by emergency stop
            throttle = p.gas_held && !p.emergency_stop;
            if (throttle && !throttle_prev) begin
                beep_next_ms = t;
                beep_next_armed = 1'b1;
            end
            if (!throttle) begin
                beep_sounding = 1'b0;
                beep_next_armed = 1'b0;
                beep_next_ms = '0;
                buzz_level = 1'b0;
            end else if (!beep_sounding &&
                         (!beep_next_armed || deadline_met(t, beep_next_ms))) begin
                beep_sounding = 1'b1;
                beep_stop_ms = t + 32'(regs.beep_len_ms);
                beep_next_ms = t + 32'(regs.gas_beep_period_ms);
                beep_next_armed = 1'b1;
                buzz_level = 1'b1;
            end else if (beep_sounding && deadline_met(t, beep_stop_ms)) begin
                beep_sounding = 1'b0;
                buzz_level = 1'b0;
            end
            throttle_prev = throttle;
        end
        // speed-change click, only while nothing else sounds
        if (!sos_latched && !beep_sounding && p.speed_change_pending) begin
            took = 1'b1;
            click_stop_ms = t + 32'(regs.click_ms);
            click_armed = 1'b1;
            buzz_level = 1'b1;
        end
        if (!sos_latched && !beep_sounding && click_armed &&
            deadline_met(t, click_stop_ms)) begin
            click_armed = 1'b0;
            click_stop_ms = '0;
            buzz_level = 1'b0;
        end
        r.buzzer_on = buzz_level;
        r.alarm_active = sos_latched;
        r.alarm_event = ev;
        r.speed_change_taken = took;
    endtask

    task automatic report_field(input string field, input logic [1:0] want,
                                input logic [1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 100)
                $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
            if (mismatches == 100)
                $display("further mismatches are counted but not shown");
        end
    endtask

    // Poll driver: pops words from the queue, inserts random idle bursts
    always @(negedge i_clk) begin
        if (!rst_n) begin
            poll_valid <= 1'b0;
        end else if (poll_valid && !poll_accepted) begin
            // hold the word until it is taken
        end else if (send_gap > 0) begin
            poll_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (poll_q.size() != 0 && $urandom_range(0, 99) < send_gap_pct) begin
            poll_valid <= 1'b0;
            send_gap <= $urandom_range(0, 16);
        end else if (poll_q.size() != 0) begin
            poll_word <= poll_q.pop_front();
            poll_valid <= 1'b1;
        end else begin
            poll_valid <= 1'b0;
        end
    end

    // Result side back-pressure in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < recv_stall_pct) begin
            stall_left <= $urandom_range(0, 16);
            res_ready <= 1'b0;
        end else begin
            res_ready <= 1'b1;
        end
    end

    // Monitor: checks result words, predicts accepted poll words
    always @(posedge i_clk) begin
        poll_accepted <= rst_n && poll_valid && o_in_ready;
        if (rst_n) begin
            if (o_out_valid && res_ready) begin
                if (buzzer_expect_q.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: expected no result word, got buzzer %0d alarm %0d",
                             $time, o_buzzer_on, o_alarm_active);
                    $display("%0t ns:   event %0d taken %0d",
                             $time, o_alarm_event, o_speed_change_taken);
                end else begin
                    exp_res = buzzer_expect_q.pop_front();
                    report_field("buzzer_on", exp_res.buzzer_on, o_buzzer_on);
                    report_field("alarm_active", exp_res.alarm_active, o_alarm_active);
                    report_field("alarm_event", exp_res.alarm_event, o_alarm_event);
                    report_field("speed_change_taken", exp_res.speed_change_taken,
                                 o_speed_change_taken);
                end
            end
            if (poll_valid && o_in_ready) begin
                buzzer_predict(poll_word, pred_res);
                buzzer_expect_q.push_back(pred_res);
                n_accepted++;
                if (pred_res.alarm_event == abp_pkg::EV_RAISED) n_raised++;
                if (pred_res.alarm_event == abp_pkg::EV_CLEARED) n_cleared++;
                if (pred_res.speed_change_taken) n_clicks++;
            end
        end
    end

    task automatic queue_poll(input logic [abp_pkg::TIME_W-1:0] t, input logic sos,
                              input logic gas, input logic estop, input logic pend);
        abp_pkg::t_poll p;
        p.now_ms = t;
        p.sos_pressed = sos;
        p.gas_held = gas;
        p.emergency_stop = estop;
        p.speed_change_pending = pend;
        poll_q.push_back(p);
        n_queued++;
    endtask

    // Mostly plausible button sequences with moving time, some noise and jumps
    task automatic queue_random(input int count, input int unsigned step_max,
                                input int unsigned sos_permille);
        int unsigned pick;
        logic [3:0]  noise;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 199);
            if (pick == 0)
                sim_ms = $urandom;
            else if (pick < 8)
                sim_ms = sim_ms + $urandom_range(0, 70000);
            else if (pick < 11)
                sim_ms = sim_ms - $urandom_range(0, step_max);
            else
                sim_ms = sim_ms + $urandom_range(0, step_max);
            if (lvl_sos)
                lvl_sos = $urandom_range(0, 99) >= 30;
            else
                lvl_sos = $urandom_range(0, 999) < sos_permille;
            lvl_gas = lvl_gas ^ ($urandom_range(0, 99) < 8);
            if (lvl_estop)
                lvl_estop = $urandom_range(0, 99) >= 40;
            else
                lvl_estop = $urandom_range(0, 99) < 4;
            if (lvl_pend)
                lvl_pend = $urandom_range(0, 99) >= 25;
            else
                lvl_pend = $urandom_range(0, 99) < 10;
            if ($urandom_range(0, 99) < 8) begin
                noise = 4'($urandom);
                queue_poll(sim_ms, noise[3], noise[2], noise[1], noise[0]);
            end else begin
                queue_poll(sim_ms, lvl_sos, lvl_gas, lvl_estop, lvl_pend);
            end
        end
    endtask

    // Wait until every poll is taken and every result word has come back
    task automatic settle();
        while (n_accepted != n_queued || buzzer_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input abp_pkg::t_reg_index idx,
                             input logic [abp_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            abp_pkg::REG_SOS_TIMEOUT:     regs.alarm_hold_ms = val;
            abp_pkg::REG_SOS_TOGGLE:      regs.sos_toggle_ms = val;
            abp_pkg::REG_GAS_BEEP_ON:     regs.beep_len_ms = val;
            abp_pkg::REG_GAS_BEEP_PERIOD: regs.gas_beep_period_ms = val;
            abp_pkg::REG_CLICK:           regs.click_ms = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [abp_pkg::CFG_W-1:0] timeout,
                                input logic [abp_pkg::CFG_W-1:0] toggle,
                                input logic [abp_pkg::CFG_W-1:0] beep_on,
                                input logic [abp_pkg::CFG_W-1:0] period,
                                input logic [abp_pkg::CFG_W-1:0] click);
        write_reg(abp_pkg::REG_SOS_TIMEOUT, timeout);
        write_reg(abp_pkg::REG_SOS_TOGGLE, toggle);
        write_reg(abp_pkg::REG_GAS_BEEP_ON, beep_on);
        write_reg(abp_pkg::REG_GAS_BEEP_PERIOD, period);
        write_reg(abp_pkg::REG_CLICK, click);
        n_settings++;
    endtask

    // Test sequence
    initial begin
        repeat (11) @(negedge i_clk);
        rst_n <= 1'b1;
        send_gap_pct = 20;
        recv_stall_pct = 20;

        // directed polls at reset settings
        queue_poll(32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_poll(32'd0, 1'b0, 1'b0, 1'b0, 1'b1);     // click starts, taken
        queue_poll(32'd50, 1'b0, 1'b0, 1'b0, 1'b0);    // click ends on its deadline
        queue_poll(32'd100, 1'b0, 1'b1, 1'b0, 1'b0);   // throttle press beeps at once
        queue_poll(32'd120, 1'b0, 1'b1, 1'b0, 1'b1);   // click held off by beep
        queue_poll(32'd170, 1'b0, 1'b1, 1'b0, 1'b0);   // beep ends
        queue_poll(32'd1000, 1'b0, 1'b1, 1'b0, 1'b1);  // next period beep
        queue_poll(32'd1020, 1'b0, 1'b1, 1'b1, 1'b0);  // emergency stop masks throttle
        queue_poll(32'd1040, 1'b1, 1'b1, 1'b0, 1'b0);  // SOS raised
        queue_poll(32'd1100, 1'b1, 1'b0, 1'b0, 1'b1);  // too soon to toggle
        queue_poll(32'd1300, 1'b0, 1'b0, 1'b0, 1'b0);  // toggle
        queue_poll(32'd4100, 1'b0, 1'b0, 1'b0, 1'b0);  // hold-off over, cleared
        queue_poll(32'hFFFF_FFC0, 1'b0, 1'b1, 1'b0, 1'b0);  // beep end wraps past zero
        queue_poll(32'h0000_0010, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_poll(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
        sim_ms = 32'h0001_0000;
        queue_random(315, 60, 8);
        settle();

        // short timings, receiver stalls only
        program_regs(16'd200, 16'd30, 16'd40, 16'd150, 16'd25);
        send_gap_pct = 0;
        recv_stall_pct = 30;
        queue_random(315, 40, 30);
        settle();

        // every register zero
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_gap_pct = 30;
        recv_stall_pct = 0;
        queue_poll(sim_ms, 1'b1, 1'b0, 1'b0, 1'b0);           // raised and cleared at once
        queue_poll(sim_ms + 1, 1'b0, 1'b1, 1'b0, 1'b0);       // beep starts
        queue_poll(sim_ms + 1, 1'b0, 1'b1, 1'b0, 1'b0);       // zero-length beep ends
        queue_poll(sim_ms + 2, 1'b0, 1'b0, 1'b0, 1'b1);       // click starts and ends
        queue_random(315, 10, 30);
        settle();

        // every register at its top, time close to wrapping
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_gap_pct = 10;
        recv_stall_pct = 10;
        sim_ms = 32'hFFFF_0000;
        queue_random(315, 2000, 5);
        settle();

        // random timings with a zero toggle interval
        program_regs(16'($urandom_range(100, 4000)), 16'd0, 16'($urandom_range(0, 200)),
                     16'($urandom_range(0, 1000)), 16'($urandom_range(0, 100)));
        send_gap_pct = 25;
        recv_stall_pct = 25;
        queue_random(315, 100, 10);
        settle();

        // one- and two-millisecond timings, full rate both sides
        program_regs(16'd1, 16'd1, 16'd1, 16'd2, 16'd1);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        queue_random(315, 3, 20);
        settle();

        $display("Ran %0d polls over %0d register settings after reset values",
                 n_accepted, n_settings);
        $display("Alarms raised %0d, cleared %0d, speed-change clicks %0d",
                 n_raised, n_cleared, n_clicks);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("Watchdog expired at %0t ns", $time);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
sv/abp_pkg.sv
sv/abp_step.sv
sv/alarm_buzzer_pattern_controller.sv
sv/abp_chk.sv
tb/sv/tb_alarm_buzzer_pattern_controller.sv
